[rtl/grlos_pkg.sv]
// Package for the grid line-of-sight core: payload structs, widths and constants.
// No dependencies.
package grlos_pkg;

  localparam int MapSide   = 128;
  localparam int CellW     = 7;
  localparam int FracW     = 8;
  localparam int PosW      = 15;
  localparam int DirW      = 16;
  localparam int DistW     = 24;
  localparam int MagW      = 15;
  localparam int AddrW     = 14;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    logic                  op;
    logic [CellW-1:0]      cell_x;
    logic [CellW-1:0]      cell_y;
    logic                  cell_blocked;
    logic [PosW-1:0]       start_x;
    logic [PosW-1:0]       start_y;
    logic signed [DirW-1:0] dir_x;
    logic signed [DirW-1:0] dir_y;
    logic [7:0]            step_limit;
  } in_item_t;

  typedef struct packed {
    logic             clear;
    logic [CellW-1:0] stop_x;
    logic [CellW-1:0] stop_y;
    logic             left_map;
  } out_item_t;

  // Divider handshake between sequencer and shared divide unit.
  typedef struct packed {
    logic             start;
    logic [MagW+1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DistW-1:0] quot;
  } div_rsp_t;

endpackage

[rtl/grid_ray_line_of_sight_core.sv]
// Top level of the grid line-of-sight core: handshake, query sequencer and DDA walk.
// Depends on grlos_pkg, grlos_div and grlos_map.
//
//  channel | ports                       | direction
//  in      | in_valid, in_stall, in_data  | item in (write or query)
//  out     | out_valid, out_stall, out_data | query result
//
// A query runs two divisions in the shared divider (x, then y), then the side
// distances, then for each tested cell a check, a map read and a test, and
// finishes with the output. After reset a sweep clears the map, during which
// in_stall is high. The result waits in out_data while out_stall is high and
// the next item may be taken meanwhile; a finished query holds until the
// output register is free.
module grid_ray_line_of_sight_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  grlos_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output grlos_pkg::out_item_t  out_data
);
  import grlos_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DIVX, S_WAITX, S_DIVY, S_WAITY, S_SIDEX, S_SIDEY,
    S_CHECK, S_READ, S_TEST, S_DONE
  } state_t;

  localparam int CoordW = CellW + 2;

  state_t            state_r, state_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  out_item_t         res_r, res_nxt;
  logic [PosW-1:0]   sx_r, sx_nxt, sy_r, sy_nxt;
  logic              nx_r, nx_nxt, ny_r, ny_nxt;
  logic [MagW+1:0]   mx_r, mx_nxt, my_r, my_nxt;
  logic [7:0]        lim_r, lim_nxt, steps_r, steps_nxt;
  logic [DistW-1:0]  dx_r, dx_nxt, dy_r, dy_nxt, sdx_r, sdx_nxt, sdy_r, sdy_nxt;
  logic signed [CoordW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [CoordW-1:0] ccx, ccy;

  div_req_t          dreq;
  div_rsp_t          drsp;
  logic              map_we, map_rd, map_init;
  logic [AddrW-1:0]  map_wa, map_ra;

  // shared multiply for the first side distances
  logic [PosW-1:0]   mpos;
  logic              mneg;
  logic [DistW-1:0]  mdel;
  logic [FracW:0]    dfrac;
  logic [DistW+FracW:0] prod;
  logic [DistW:0]    sat_in;
  logic [DistW-1:0]  side_val;
  // shared add for the walk
  logic              step_x;
  logic [DistW:0]    sum;
  logic              out_map;

  function automatic logic [MagW+1:0] mag(input logic [DirW-1:0] v);
    logic [DirW:0] t;
    t = v[DirW-1] ? ({1'b1, {DirW{1'b0}}} - {1'b0, v}) : {1'b0, v};
    return t[MagW+1:0];
  endfunction

  function automatic logic signed [CoordW-1:0] clamp(input logic signed [CoordW-1:0] c);
    if (c < 0) return '0;
    if (c > CoordW'(MapSide - 1)) return CoordW'(MapSide - 1);
    return c;
  endfunction

  grlos_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  grlos_map u_map (
    .clk(clk), .rst_n(rst_n), .wr_en(map_we), .wr_addr(map_wa),
    .wr_data(in_data.cell_blocked), .rd_addr(map_ra), .rd_data(map_rd),
    .init_done(map_init)
  );

  assign in_stall  = !map_init || state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign map_we = in_valid && !in_stall && in_data.op == OP_WRITE;
  assign map_wa = {in_data.cell_y, in_data.cell_x};
  assign map_ra = {cy_r[CellW-1:0], cx_r[CellW-1:0]};

  always_comb begin
    mpos   = (state_r == S_SIDEX) ? sx_r : sy_r;
    mneg   = (state_r == S_SIDEX) ? nx_r : ny_r;
    mdel   = (state_r == S_SIDEX) ? dx_r : dy_r;
    dfrac  = mneg ? {1'b0, mpos[FracW-1:0]}
                  : ((FracW+1)'(1) << FracW) - {1'b0, mpos[FracW-1:0]};
    prod   = (DistW+FracW+1)'(dfrac) * (DistW+FracW+1)'(mdel);
    sat_in = prod[DistW+FracW:FracW];
    side_val = sat_in[DistW] ? DistMax : sat_in[DistW-1:0];
    step_x = sdx_r < sdy_r;
    sum    = step_x ? ({1'b0, sdx_r} + {1'b0, dx_r}) : ({1'b0, sdy_r} + {1'b0, dy_r});
    out_map = cx_r < 0 || cx_r >= CoordW'(MapSide) || cy_r < 0 || cy_r >= CoordW'(MapSide);
    ccx    = clamp(cx_r);
    ccy    = clamp(cy_r);
  end

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    res_nxt = res_r;
    sx_nxt = sx_r; sy_nxt = sy_r; nx_nxt = nx_r; ny_nxt = ny_r;
    mx_nxt = mx_r; my_nxt = my_r; lim_nxt = lim_r; steps_nxt = steps_r;
    dx_nxt = dx_r; dy_nxt = dy_r; sdx_nxt = sdx_r; sdy_nxt = sdy_r;
    cx_nxt = cx_r; cy_nxt = cy_r;
    dreq.start = 1'b0;
    dreq.divisor = (state_r == S_DIVX) ? mx_r : my_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall && in_data.op == OP_QUERY) begin
          sx_nxt  = in_data.start_x;
          sy_nxt  = in_data.start_y;
          nx_nxt  = in_data.dir_x[DirW-1];
          ny_nxt  = in_data.dir_y[DirW-1];
          mx_nxt  = mag(in_data.dir_x);
          my_nxt  = mag(in_data.dir_y);
          lim_nxt = in_data.step_limit;
          state_nxt = S_DIVX;
        end
      end
      S_DIVX: begin
        dreq.start = 1'b1;
        state_nxt = S_WAITX;
      end
      S_WAITX: begin
        if (drsp.done) begin
          dx_nxt = drsp.quot;
          state_nxt = S_DIVY;
        end
      end
      S_DIVY: begin
        dreq.start = 1'b1;
        state_nxt = S_WAITY;
      end
      S_WAITY: begin
        if (drsp.done) begin
          dy_nxt = drsp.quot;
          state_nxt = S_SIDEX;
        end
      end
      S_SIDEX: begin
        sdx_nxt = side_val;
        state_nxt = S_SIDEY;
      end
      S_SIDEY: begin
        sdy_nxt = side_val;
        cx_nxt = CoordW'(sx_r >> FracW);
        cy_nxt = CoordW'(sy_r >> FracW);
        steps_nxt = '0;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (steps_r == lim_r) begin
          res_nxt = '{clear: 1'b1, stop_x: ccx[CellW-1:0],
                      stop_y: ccy[CellW-1:0], left_map: 1'b0};
          state_nxt = S_DONE;
        end else if (out_map) begin
          res_nxt = '{clear: 1'b0, stop_x: ccx[CellW-1:0],
                      stop_y: ccy[CellW-1:0], left_map: 1'b1};
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_TEST;
      end
      S_TEST: begin
        if (map_rd) begin
          res_nxt = '{clear: 1'b0, stop_x: cx_r[CellW-1:0],
                      stop_y: cy_r[CellW-1:0], left_map: 1'b0};
          state_nxt = S_DONE;
        end else begin
          // advance along the axis with the nearer boundary
          if (step_x) begin
            cx_nxt  = nx_r ? cx_r - 1'b1 : cx_r + 1'b1;
            sdx_nxt = sum[DistW] ? DistMax : sum[DistW-1:0];
          end else begin
            cy_nxt  = ny_r ? cy_r - 1'b1 : cy_r + 1'b1;
            sdy_nxt = sum[DistW] ? DistMax : sum[DistW-1:0];
          end
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_DONE: begin
        // hold until the previous result has left the output register
        if (!out_valid_r || !out_stall) begin
          out_nxt = res_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
    res_r <= res_nxt;
    sx_r <= sx_nxt; sy_r <= sy_nxt; nx_r <= nx_nxt; ny_r <= ny_nxt;
    mx_r <= mx_nxt; my_r <= my_nxt; lim_r <= lim_nxt; steps_r <= steps_nxt;
    dx_r <= dx_nxt; dy_r <= dy_nxt; sdx_r <= sdx_nxt; sdy_r <= sdy_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt;
  end

`ifndef NO_ASSERTIONS
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_r))
    else $error("result dropped under stall");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> in_stall) else $error("input taken while busy");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> out_valid_r) else $error("result not raised");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_TEST |-> steps_r < lim_r) else $error("step past limit");
`endif
endmodule

[rtl/grlos_div.sv]
// Radix-2 restoring divider: 2^22 / divisor, one quotient bit per cycle, zero-extended to 24 bits.
// Depends on grlos_pkg.
module grlos_div (
  input  logic                clk,
  input  logic                rst_n,
  input  grlos_pkg::div_req_t req,
  output grlos_pkg::div_rsp_t rsp
);
  import grlos_pkg::*;

  localparam int NumW = 23;
  localparam int CntW = 5;

  logic [NumW-1:0] num_r, num_nxt;
  logic [NumW-1:0] rem_r, rem_nxt;
  logic [NumW-1:0] quo_r, quo_nxt;
  logic [MagW+1:0] dvs_r, dvs_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [NumW:0]   trial;
  logic [NumW:0]   diff;

  always_comb begin
    trial = {rem_r, num_r[NumW-1]};
    diff  = trial - {{(NumW-MagW-1){1'b0}}, dvs_r};
    num_nxt = num_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      num_nxt = NumW'(1) << 22;
      rem_nxt = '0;
      quo_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = CntW'(NumW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = num_r << 1;
      if (!diff[NumW]) begin
        rem_nxt = diff[NumW-1:0];
        quo_nxt = {quo_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[NumW-1:0];
        quo_nxt = {quo_r[NumW-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  // Zero divisor reports the largest distance.
  assign rsp.done = done_r;
  assign rsp.quot = (dvs_r == '0) ? DistMax : DistW'(quo_r);

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("divider did not start");
`endif
endmodule

[rtl/grlos_map.sv]
// Occupancy bitmap: one write port, one registered read port, clearing sweep after reset.
// Depends on grlos_pkg.
module grlos_map (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [grlos_pkg::AddrW-1:0] wr_addr,
  input  logic                       wr_data,
  input  logic [grlos_pkg::AddrW-1:0] rd_addr,
  output logic                       rd_data,
  output logic                       init_done
);
  import grlos_pkg::*;

  logic              mem [MapSide*MapSide];
  logic [AddrW:0]    clr_r, clr_nxt;
  logic              we;
  logic [AddrW-1:0]  wa;
  logic              wd;

  assign init_done = clr_r[AddrW];
  assign clr_nxt   = init_done ? clr_r : clr_r + 1'b1;

  always_comb begin
    if (!init_done) begin
      we = 1'b1;
      wa = clr_r[AddrW-1:0];
      wd = 1'b0;
    end else begin
      we = wr_en;
      wa = wr_addr;
      wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[rd_addr];
  end

`ifndef NO_ASSERTIONS
  a_sweep_mono: assert property (@(posedge clk) disable iff (!rst_n)
    init_done |=> init_done) else $error("clear sweep restarted");
  a_no_wr_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |-> !clr_nxt[AddrW] || clr_r == {1'b0, {AddrW{1'b1}}})
    else $error("sweep count skipped");
  a_sweep_adv: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |=> clr_r == $past(clr_r) + 1'b1) else $error("sweep stalled");
`endif
endmodule
